FILE: sv/numeric_literal_recognizer_core_defines.svh
// ---------------------------------------------------------------------------
// Numeric literal recognizer assertion macros
// Shorthand for clocked implication checks used by the core.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_RECOGNIZER_CORE_DEFINES_SVH
`define NUMERIC_LITERAL_RECOGNIZER_CORE_DEFINES_SVH

// same-cycle implication
`define NLR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NLR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/nlr_pkg.sv
// ---------------------------------------------------------------------------
// Numeric literal recognizer package
// Shared types, character codes and helper functions.
// ---------------------------------------------------------------------------
package nlr_pkg;

   localparam int LEN_W = 16;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ZERO  = 4'd1,
      PH_BIN   = 4'd2,
      PH_OCT   = 4'd3,
      PH_HEX   = 4'd4,
      PH_INT   = 4'd5,
      PH_DOT   = 4'd6,
      PH_FRAC  = 4'd7,
      PH_ESIGN = 4'd8,
      PH_EXP   = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      OUT_INT    = 3'd0,
      OUT_FLOAT  = 3'd1,
      OUT_NO_BIN = 3'd2,
      OUT_NO_OCT = 3'd3,
      OUT_NO_HEX = 3'd4,
      OUT_BAD_US = 3'd5,
      OUT_NO_EXP = 3'd6
   } outcome_type;

   localparam logic [7:0] CH_US    = 8'h5F;  // '_'
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
   localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
   localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
   localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
   localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_LO    = 8'h6F;  // 'o'
   localparam logic [7:0] CH_UO    = 8'h4F;
   localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LE    = 8'h65;  // 'e'
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef struct packed {
      logic [7:0] ch;
      logic       begin_token;
      logic       end_of_input;
   } nlr_item_type;

   typedef struct packed {
      phase_type        phase;
      logic             underscore_last;
      logic             digit_seen;
      logic             float_flag;
      logic             dot_pending;
      logic [LEN_W-1:0] length_count;
   } nlr_state_type;

   typedef struct packed {
      logic             fire;
      outcome_type      outcome;
      logic [LEN_W-1:0] token_length;
   } nlr_result_type;

   localparam nlr_state_type STATE_CLEAR = '{
      phase: PH_IDLE, underscore_last: 1'b0, digit_seen: 1'b0,
      float_flag: 1'b0, dot_pending: 1'b0, length_count: '0};

   function automatic logic is_dec(logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_bin(logic [7:0] c);
      return (c == CH_0) || (c == CH_1);
   endfunction

   function automatic logic is_oct(logic [7:0] c);
      return (c >= CH_0) && (c <= CH_7);
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
             ((c >= CH_UA) && (c <= CH_UF));
   endfunction

   function automatic logic [LEN_W-1:0] sat_inc(logic [LEN_W-1:0] v);
      return (v == LEN_MAX) ? v : v + LEN_W'(1);
   endfunction

endpackage

FILE: sv/numeric_literal_recognizer_core.sv
// ---------------------------------------------------------------------------
// Numeric literal recognizer core
// Streams source bytes and reports each numeric literal's kind and length.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one source byte per transfer. tdata carries the byte, tuser
//            flags the first digit of a new token, tlast marks end of input
//            (no byte carried then).
//   rsp_*  : one transfer per finished token: outcome code and the count of
//            characters consumed. The byte that ends a token is not consumed
//            and belongs to the caller's next token.
//   Path:    an accepted byte sits in the input register, is stepped by
//            nlr_step from there, and a result it closes is loaded into
//            the result register and driven on rsp_tdata.
//   Throughput: one byte per cycle when not stalled; the one-step state
//            update between the input and result registers sets this figure.
//   Stall: while rsp_tready is low and a result is waiting, bytes that
//            close no token still advance; a byte that would close one
//            waits in the input register, and req_tready drops.
//   Reset: synchronous, clears both valid flags and the scanner state
//            (idle, no token open).
// ---------------------------------------------------------------------------
module numeric_literal_recognizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] begin_token
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [2:0] outcome, [18:3] token_length, zero fill
);
   import nlr_pkg::*;

`include "numeric_literal_recognizer_core_defines.svh"

   // input register
   logic            in_valid_ff, in_valid_in;
   nlr_item_type    in_item_ff,  in_item_in;

   // scanner state
   nlr_state_type   state_ff, state_in;
   nlr_state_type   step_nxt;
   nlr_result_type  step_res;

   // result register
   logic              out_valid_ff, out_valid_in;
   outcome_type       out_code_ff,  out_code_in;
   logic [LEN_W-1:0]  out_len_ff,   out_len_in;

   logic advance;

   nlr_step u_step (
      .item (in_item_ff),
      .cur  (state_ff),
      .nxt  (step_nxt),
      .res  (step_res)
   );

   // a held byte moves on unless it closes a token while the result slot is full and rsp_tready is low
   assign advance    = in_valid_ff && (!step_res.fire || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_item_in  = '{ch: req_tdata, begin_token: req_tuser, end_of_input: req_tlast};
      end
   end

   assign state_in = advance ? step_nxt : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_len_in   = out_len_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && step_res.fire) begin
         out_valid_in = 1'b1;
         out_code_in  = step_res.outcome;
         out_len_in   = step_res.token_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_code_ff <= out_code_in;
      out_len_ff  <= out_len_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_len_ff, out_code_ff};

   `NLR_ASSERT_NXT(a_hold_input, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_item_ff), "held byte lost or changed")
   `NLR_ASSERT_NXT(a_result_loaded, clock, reset, advance && step_res.fire,
      out_valid_ff, "closed token produced no result")
   `NLR_ASSERT_IMP(a_idle_len, clock, reset, state_ff.phase == PH_IDLE,
      state_ff.length_count == '0, "idle scanner holds a length")
   `NLR_ASSERT_IMP(a_dot_phase, clock, reset, state_ff.dot_pending,
      state_ff.phase == PH_DOT, "held dot outside dot phase")

endmodule

FILE: sv/nlr_step.sv
// ---------------------------------------------------------------------------
// Numeric literal recognizer step
// One character's state transition and the token result it may close.
// ---------------------------------------------------------------------------
module nlr_step (
   input  nlr_pkg::nlr_item_type   item,
   input  nlr_pkg::nlr_state_type  cur,
   output nlr_pkg::nlr_state_type  nxt,
   output nlr_pkg::nlr_result_type res
);
   import nlr_pkg::*;

   logic [7:0] ch;
   logic       eoi;
   logic       is_us;
   logic       is_e;

   assign ch    = item.ch;
   assign eoi   = item.end_of_input;
   assign is_us = !eoi && (ch == CH_US);
   assign is_e  = !eoi && ((ch == CH_LE) || (ch == CH_UE));

   always_comb begin
      logic radix_dig;
      outcome_type nodig;
      radix_dig = 1'b0;
      nodig     = OUT_NO_BIN;
      nxt       = cur;
      res.fire         = 1'b0;
      res.outcome      = OUT_INT;
      res.token_length = cur.length_count;

      if (item.begin_token && !eoi) begin
         nxt = STATE_CLEAR;
         nxt.length_count = LEN_W'(1);
         nxt.phase = (ch == CH_0) ? PH_ZERO : PH_INT;
      end else begin
         case (cur.phase)
            PH_ZERO, PH_INT: begin
               if (cur.phase == PH_ZERO && !eoi && ((ch == CH_LB) || (ch == CH_UB) ||
                   (ch == CH_LO) || (ch == CH_UO) || (ch == CH_LX) || (ch == CH_UX))) begin
                  nxt.length_count    = sat_inc(cur.length_count);
                  nxt.digit_seen      = 1'b0;
                  nxt.underscore_last = 1'b0;
                  if ((ch == CH_LB) || (ch == CH_UB)) begin
                     nxt.phase = PH_BIN;
                  end else if ((ch == CH_LO) || (ch == CH_UO)) begin
                     nxt.phase = PH_OCT;
                  end else begin
                     nxt.phase = PH_HEX;
                  end
               end else begin
                  nxt.phase = PH_INT;
                  if (is_us) begin
                     if (cur.underscore_last) begin
                        res.fire = 1'b1;
                        res.outcome = OUT_BAD_US;
                        nxt = STATE_CLEAR;
                     end else begin
                        nxt.length_count    = sat_inc(cur.length_count);
                        nxt.underscore_last = 1'b1;
                     end
                  end else if (!eoi && is_dec(ch)) begin
                     nxt.length_count    = sat_inc(cur.length_count);
                     nxt.underscore_last = 1'b0;
                     nxt.digit_seen      = 1'b1;
                  end else if (!eoi && (ch == CH_DOT)) begin
                     if (cur.underscore_last) begin
                        res.fire = 1'b1;
                        res.outcome = OUT_BAD_US;
                        nxt = STATE_CLEAR;
                     end else begin
                        nxt.dot_pending = 1'b1;
                        nxt.phase       = PH_DOT;
                     end
                  end else if (is_e) begin
                     nxt.length_count    = sat_inc(cur.length_count);
                     nxt.float_flag      = 1'b1;
                     nxt.underscore_last = 1'b0;
                     nxt.digit_seen      = 1'b0;
                     nxt.phase           = PH_ESIGN;
                  end else begin
                     res.fire = 1'b1;
                     res.outcome = cur.underscore_last ? OUT_BAD_US :
                                   (cur.float_flag ? OUT_FLOAT : OUT_INT);
                     nxt = STATE_CLEAR;
                  end
               end
            end
            PH_BIN, PH_OCT, PH_HEX: begin
               if (cur.phase == PH_BIN) begin
                  radix_dig = is_bin(ch);
                  nodig     = OUT_NO_BIN;
               end else if (cur.phase == PH_OCT) begin
                  radix_dig = is_oct(ch);
                  nodig     = OUT_NO_OCT;
               end else begin
                  radix_dig = is_hex(ch);
                  nodig     = OUT_NO_HEX;
               end
               if (is_us) begin
                  if (cur.underscore_last) begin
                     res.fire = 1'b1;
                     res.outcome = OUT_BAD_US;
                     nxt = STATE_CLEAR;
                  end else begin
                     nxt.length_count    = sat_inc(cur.length_count);
                     nxt.underscore_last = 1'b1;
                  end
               end else if (!eoi && radix_dig) begin
                  nxt.length_count    = sat_inc(cur.length_count);
                  nxt.underscore_last = 1'b0;
                  nxt.digit_seen      = 1'b1;
               end else begin
                  res.fire = 1'b1;
                  res.outcome = !cur.digit_seen ? nodig :
                                (cur.underscore_last ? OUT_BAD_US : OUT_INT);
                  nxt = STATE_CLEAR;
               end
            end
            PH_DOT: begin
               if (!eoi && is_dec(ch)) begin
                  // the held dot and this digit are counted together
                  nxt.length_count    = sat_inc(sat_inc(cur.length_count));
                  nxt.dot_pending     = 1'b0;
                  nxt.float_flag      = 1'b1;
                  nxt.underscore_last = 1'b0;
                  nxt.phase           = PH_FRAC;
               end else begin
                  res.fire = 1'b1;
                  res.outcome = is_us ? OUT_BAD_US : OUT_INT;
                  nxt = STATE_CLEAR;
               end
            end
            PH_FRAC: begin
               if (is_us) begin
                  if (cur.underscore_last) begin
                     res.fire = 1'b1;
                     res.outcome = OUT_BAD_US;
                     nxt = STATE_CLEAR;
                  end else begin
                     nxt.length_count    = sat_inc(cur.length_count);
                     nxt.underscore_last = 1'b1;
                  end
               end else if (!eoi && is_dec(ch)) begin
                  nxt.length_count    = sat_inc(cur.length_count);
                  nxt.underscore_last = 1'b0;
                  nxt.digit_seen      = 1'b1;
               end else if (is_e) begin
                  nxt.length_count    = sat_inc(cur.length_count);
                  nxt.float_flag      = 1'b1;
                  nxt.underscore_last = 1'b0;
                  nxt.digit_seen      = 1'b0;
                  nxt.phase           = PH_ESIGN;
               end else begin
                  res.fire = 1'b1;
                  res.outcome = cur.underscore_last ? OUT_BAD_US :
                                (cur.float_flag ? OUT_FLOAT : OUT_INT);
                  nxt = STATE_CLEAR;
               end
            end
            PH_ESIGN, PH_EXP: begin
               nxt.phase = PH_EXP;
               if (cur.phase == PH_ESIGN && !eoi &&
                   ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
                  nxt.length_count = sat_inc(cur.length_count);
               end else if (is_us) begin
                  if (cur.underscore_last) begin
                     res.fire = 1'b1;
                     res.outcome = OUT_BAD_US;
                     nxt = STATE_CLEAR;
                  end else begin
                     nxt.length_count    = sat_inc(cur.length_count);
                     nxt.underscore_last = 1'b1;
                  end
               end else if (!eoi && is_dec(ch)) begin
                  nxt.length_count    = sat_inc(cur.length_count);
                  nxt.underscore_last = 1'b0;
                  nxt.digit_seen      = 1'b1;
               end else begin
                  res.fire = 1'b1;
                  res.outcome = !cur.digit_seen ? OUT_NO_EXP :
                                (cur.underscore_last ? OUT_BAD_US : OUT_FLOAT);
                  nxt = STATE_CLEAR;
               end
            end
            default: begin
               // idle: bytes outside a token are ignored
               nxt = cur;
            end
         endcase
      end
   end

endmodule
